// ===== rtl/icaf_pkg.sv =====
// Package for the IMU complementary angle filter: word types, constants,
// arctangent table and the controller state encoding. No dependencies.
`default_nettype none
package icaf_pkg;

    localparam int CORDIC_ITERS = 28;
    localparam int ITER_W = 5;

    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;

    // rounding divides: inc = round(x / 1e6), blend = round(x / 20);
    // the power-of-two factor of each divisor is shifted out first
    localparam logic [63:0] INC_HALF    = 64'd500000;
    localparam logic [63:0] BLEND_HALF  = 64'd10;
    localparam logic [19:0] INC_DEN     = 20'd15625;        // 1e6 / 64
    localparam logic [19:0] BLEND_DEN   = 20'd5;            // 20 / 4
    localparam logic [31:0] INC_RECIP   = 32'd2251799813;   // floor(2^45 / 15625)
    localparam logic [31:0] BLEND_RECIP = 32'd3435973836;   // floor(2^34 / 5)

    typedef struct packed {
        logic signed [23:0] rate_a_roll;
        logic signed [23:0] rate_a_pitch;
        logic signed [23:0] rate_a_yaw;
        logic signed [23:0] rate_b_roll;
        logic signed [23:0] rate_b_pitch;
        logic signed [23:0] rate_b_yaw;
        logic signed [23:0] accel_x;
        logic signed [23:0] accel_y;
        logic signed [23:0] accel_z;
        logic signed [23:0] mag_x;
        logic signed [23:0] mag_y;
        logic [15:0]        time_step_us;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] gyro_a_roll;
        logic signed [31:0] gyro_a_pitch;
        logic signed [31:0] gyro_a_yaw;
        logic signed [31:0] gyro_b_roll;
        logic signed [31:0] gyro_b_pitch;
        logic signed [31:0] gyro_b_yaw;
        logic signed [31:0] ref_roll;
        logic signed [31:0] ref_pitch;
        logic signed [31:0] ref_yaw;
        logic signed [31:0] fused_roll;
        logic signed [31:0] fused_pitch;
        logic signed [31:0] fused_yaw;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC_START,
        ST_CORDIC_RUN,
        ST_CORDIC_STORE,
        ST_INC_MUL,
        ST_INC_DIV,
        ST_INC_STORE,
        ST_BLEND_MUL,
        ST_BLEND_DIV,
        ST_BLEND_STORE,
        ST_OUTPUT
    } state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_REM,
        DV_FIX
    } div_state_t;

    typedef struct packed {
        logic       load;        // capture input word
        logic       cordic_init;
        logic       cordic_step;
        logic       ref_store;
        logic       inc_mul;
        logic       div_start;
        logic       inc_store;
        logic       blend_mul;
        logic       blend_store;
        logic       out_load;
        logic [1:0] axis;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cordic_last;
        logic div_done;
    } ctrl_stat_t;

    function automatic logic signed [31:0] atan_entry(input logic [ITER_W-1:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:  r = 32'sd210828714;
            5'd1:  r = 32'sd124459457;
            5'd2:  r = 32'sd65760959;
            5'd3:  r = 32'sd33381290;
            5'd4:  r = 32'sd16755422;
            5'd5:  r = 32'sd8385879;
            5'd6:  r = 32'sd4193963;
            5'd7:  r = 32'sd2097109;
            5'd8:  r = 32'sd1048571;
            5'd9:  r = 32'sd524287;
            5'd10: r = 32'sd262144;
            5'd11: r = 32'sd131072;
            5'd12: r = 32'sd65536;
            5'd13: r = 32'sd32768;
            5'd14: r = 32'sd16384;
            5'd15: r = 32'sd8192;
            5'd16: r = 32'sd4096;
            5'd17: r = 32'sd2048;
            5'd18: r = 32'sd1024;
            5'd19: r = 32'sd512;
            5'd20: r = 32'sd256;
            5'd21: r = 32'sd128;
            5'd22: r = 32'sd64;
            5'd23: r = 32'sd32;
            5'd24: r = 32'sd16;
            5'd25: r = 32'sd8;
            5'd26: r = 32'sd4;
            5'd27: r = 32'sd2;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/icaf_div.sv =====
// Rounding divider for the two fixed divisors (1e6 and 20): reciprocal multiply
// estimate, then remainder correction, ties away from zero. Uses icaf_pkg.
`default_nettype none
module icaf_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               blend,
    input  wire logic signed [63:0] num,
    output logic signed [63:0]      quo,
    output logic                    done
);
    icaf_pkg::div_state_t state_reg, state_next;
    logic [45:0] b_reg, b_next;
    logic [31:0] q_reg, q_next;
    logic [19:0] r_reg, r_next;
    logic        blend_reg, blend_next;
    logic        neg_reg, neg_next;
    logic [63:0] absn, b_sum;
    logic [19:0] den;
    logic [31:0] est_op, recip;
    logic [63:0] prod;
    logic [45:0] back, diff;

    // divisor and estimate operands of the division in flight
    always_comb
    begin
        den    = blend_reg ? icaf_pkg::BLEND_DEN : icaf_pkg::INC_DEN;
        recip  = blend_reg ? icaf_pkg::BLEND_RECIP : icaf_pkg::INC_RECIP;
        est_op = blend_reg ? b_reg[33:2] : b_reg[45:14];
        prod   = 64'(est_op) * 64'(recip);
        back   = 46'(q_reg) * 46'(den);
        diff   = b_reg - back;
    end

    always_comb
    begin
        state_next = state_reg;
        if (start)
            state_next = icaf_pkg::DV_MUL;
        else
        begin
            case (state_reg)
                icaf_pkg::DV_IDLE: state_next = icaf_pkg::DV_IDLE;
                icaf_pkg::DV_MUL:  state_next = icaf_pkg::DV_REM;
                icaf_pkg::DV_REM:  state_next = icaf_pkg::DV_FIX;
                icaf_pkg::DV_FIX:
                    if (r_reg < den) state_next = icaf_pkg::DV_IDLE;
                default: state_next = icaf_pkg::DV_IDLE;
            endcase
        end
    end

    always_comb
    begin
        absn = num[63] ? 64'(-num) : 64'(num);
        b_sum = absn + (blend ? icaf_pkg::BLEND_HALF : icaf_pkg::INC_HALF);
        b_next     = b_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        blend_next = blend_reg;
        neg_next   = neg_reg;
        if (start)
        begin
            // bias for rounding, then drop the divisor's power-of-two factor
            b_next     = blend ? 46'(b_sum >> 2) : 46'(b_sum >> 6);
            blend_next = blend;
            neg_next   = num[63];
        end
        else
        begin
            case (state_reg)
                // estimate never exceeds the true quotient, short by at most 4
                icaf_pkg::DV_MUL: q_next = blend_reg ? prod[63:32] : prod[62:31];
                icaf_pkg::DV_REM: r_next = diff[19:0];
                icaf_pkg::DV_FIX:
                    if (r_reg >= den)
                    begin
                        r_next = r_reg - den;
                        q_next = q_reg + 32'd1;
                    end
                default: q_next = q_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= icaf_pkg::DV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        blend_reg <= blend_next;
        neg_reg   <= neg_next;
    end

    assign done = (state_reg == icaf_pkg::DV_FIX) && (r_reg < den);
    assign quo  = neg_reg ? -$signed(64'(q_reg)) : $signed(64'(q_reg));
endmodule
`default_nettype wire

// ===== rtl/icaf_ctrl.sv =====
// Sequencer for the filter: three CORDIC passes, then per axis the gyro
// increments and the blend. Uses icaf_pkg types.
`default_nettype none
module icaf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  out_full,
    input  wire icaf_pkg::ctrl_stat_t  stat,
    output icaf_pkg::ctrl_cmd_t        cmd
);
    icaf_pkg::state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       gyro_b_reg, gyro_b_next;   // second increment of an axis

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        gyro_b_next = gyro_b_reg;
        case (state_reg)
            icaf_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = icaf_pkg::ST_CORDIC_START;
                    axis_next = 2'd0;
                end
            icaf_pkg::ST_CORDIC_START: state_next = icaf_pkg::ST_CORDIC_RUN;
            icaf_pkg::ST_CORDIC_RUN:
                if (stat.cordic_last) state_next = icaf_pkg::ST_CORDIC_STORE;
            icaf_pkg::ST_CORDIC_STORE:
                if (axis_reg == 2'd2)
                begin
                    axis_next = 2'd0;
                    gyro_b_next = 1'b0;
                    state_next = icaf_pkg::ST_INC_MUL;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                    state_next = icaf_pkg::ST_CORDIC_START;
                end
            icaf_pkg::ST_INC_MUL: state_next = icaf_pkg::ST_INC_DIV;
            icaf_pkg::ST_INC_DIV:
                if (stat.div_done) state_next = icaf_pkg::ST_INC_STORE;
            icaf_pkg::ST_INC_STORE:
                if (gyro_b_reg)
                begin
                    gyro_b_next = 1'b0;
                    state_next = icaf_pkg::ST_BLEND_MUL;
                end
                else
                begin
                    gyro_b_next = 1'b1;
                    state_next = icaf_pkg::ST_INC_MUL;
                end
            icaf_pkg::ST_BLEND_MUL: state_next = icaf_pkg::ST_BLEND_DIV;
            icaf_pkg::ST_BLEND_DIV:
                if (stat.div_done) state_next = icaf_pkg::ST_BLEND_STORE;
            icaf_pkg::ST_BLEND_STORE:
                if (axis_reg == 2'd2)
                    state_next = icaf_pkg::ST_OUTPUT;
                else
                begin
                    axis_next = axis_reg + 2'd1;
                    state_next = icaf_pkg::ST_INC_MUL;
                end
            icaf_pkg::ST_OUTPUT:
                if (!out_full) state_next = icaf_pkg::ST_IDLE;
            default: state_next = icaf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.axis = axis_reg;
        in_stall = 1'b1;
        case (state_reg)
            icaf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            icaf_pkg::ST_CORDIC_START: cmd.cordic_init = 1'b1;
            icaf_pkg::ST_CORDIC_RUN:   cmd.cordic_step = 1'b1;
            icaf_pkg::ST_CORDIC_STORE: cmd.ref_store = 1'b1;
            icaf_pkg::ST_INC_MUL:
            begin
                cmd.inc_mul = 1'b1;
                cmd.div_start = 1'b0;
            end
            icaf_pkg::ST_INC_DIV:      cmd.div_start = 1'b0;
            icaf_pkg::ST_INC_STORE:    cmd.inc_store = 1'b1;
            icaf_pkg::ST_BLEND_MUL:    cmd.blend_mul = 1'b1;
            icaf_pkg::ST_BLEND_DIV:    cmd.div_start = 1'b0;
            icaf_pkg::ST_BLEND_STORE:  cmd.blend_store = 1'b1;
            icaf_pkg::ST_OUTPUT:       cmd.out_load = !out_full;
            default: cmd = '0;
        endcase
        // divider kicks off in the same cycle as the operand register loads, taking the operand combinationally
        cmd.div_start = (state_reg == icaf_pkg::ST_INC_MUL)
                     || (state_reg == icaf_pkg::ST_BLEND_MUL);
        cmd.inc_mul = cmd.inc_mul && !gyro_b_reg ? 1'b1 : cmd.inc_mul;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= icaf_pkg::ST_IDLE;
            axis_reg   <= 2'd0;
            gyro_b_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            gyro_b_reg <= gyro_b_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/icaf_datapath.sv =====
// Datapath: input capture, one shared CORDIC vectoring unit, rate*dt
// product, shared rounding divider, angle state and result word. Uses icaf_pkg.
`default_nettype none
module icaf_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wrap_enable,
    input  wire icaf_pkg::in_word_t   in_word,
    input  wire icaf_pkg::ctrl_cmd_t  cmd,
    input  wire logic                 inc_b,
    output icaf_pkg::ctrl_stat_t      stat,
    output icaf_pkg::out_word_t       out_word
);
    icaf_pkg::in_word_t in_reg;

    // CORDIC: operands scaled by 2^32 fit in 58 bits with growth
    logic signed [59:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0] cz_reg, cz_next;
    logic [icaf_pkg::ITER_W-1:0] it_reg, it_next;
    logic        zero_reg, zero_next;
    logic signed [23:0] ay, ax;
    logic signed [59:0] sx, sy, xs, ys;

    logic signed [31:0] ref_reg [3];
    logic signed [31:0] ga_reg [3];
    logic signed [31:0] gb_reg [3];
    logic signed [31:0] fu_reg [3];
    logic signed [63:0] inc_a_reg;

    logic signed [63:0] num_reg, num_next;
    logic signed [63:0] quo;
    logic               div_done;
    logic signed [23:0] rate;
    logic signed [63:0] s_sum, s_sat, integ;
    logic signed [31:0] old_g;

    // operands of the current reference
    always_comb
    begin
        case (cmd.axis)
            2'd0:
            begin
                ay = -in_reg.accel_y;
                ax = in_reg.accel_z;
            end
            2'd1:
            begin
                ay = in_reg.accel_x;
                ax = in_reg.accel_z;
            end
            default:
            begin
                ay = in_reg.mag_y;
                ax = in_reg.mag_x;
            end
        endcase
    end

    always_comb
    begin
        sx = 60'(ax) <<< 32;
        sy = (ay == -24'sd8388608) ? (60'sd8388608 <<< 32) : (60'(ay) <<< 32);
        if (cmd.axis == 2'd0 && in_reg.accel_y == -24'sd8388608)
            sy = 60'sd8388608 <<< 32;
        else if (cmd.axis == 2'd0)
            sy = -(60'(in_reg.accel_y) <<< 32);
        else
            sy = 60'(ay) <<< 32;
        xs = cx_reg >>> it_reg;
        ys = cy_reg >>> it_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        it_next = it_reg;
        zero_next = zero_reg;
        if (cmd.cordic_init)
        begin
            zero_next = (ax == 24'sd0) && (sy == 60'sd0);
            it_next = '0;
            if (sx < 0)
            begin
                if (sy >= 0)
                begin
                    cx_next = sy;
                    cy_next = -sx;
                    cz_next = icaf_pkg::HALF_PI_Q28;
                end
                else
                begin
                    cx_next = -sy;
                    cy_next = sx;
                    cz_next = -icaf_pkg::HALF_PI_Q28;
                end
            end
            else
            begin
                cx_next = sx;
                cy_next = sy;
                cz_next = '0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (cy_reg >= 0)
            begin
                cx_next = cx_reg + ys;
                cy_next = cy_reg - xs;
                cz_next = cz_reg + icaf_pkg::atan_entry(it_reg);
            end
            else
            begin
                cx_next = cx_reg - ys;
                cy_next = cy_reg + xs;
                cz_next = cz_reg - icaf_pkg::atan_entry(it_reg);
            end
            it_next = it_reg + 1'b1;
        end
    end

    assign stat.cordic_last = cmd.cordic_step
                           && (it_reg == icaf_pkg::ITER_W'(icaf_pkg::CORDIC_ITERS - 1));
    assign stat.div_done = div_done;

    always_comb
    begin
        case (cmd.axis)
            2'd0: rate = inc_b ? in_reg.rate_b_roll : in_reg.rate_a_roll;
            2'd1: rate = inc_b ? in_reg.rate_b_pitch : in_reg.rate_a_pitch;
            default: rate = inc_b ? in_reg.rate_b_yaw : in_reg.rate_a_yaw;
        endcase
        num_next = num_reg;
        if (cmd.inc_mul)
            num_next = (64'(rate) * $signed({1'b0, in_reg.time_step_us})) <<< 12;
        else if (cmd.blend_mul)
            num_next = 64'(ref_reg[cmd.axis]) + 64'(s_sat) * 64'sd19;
    end

    icaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .blend (cmd.blend_mul),
        .num   (num_next),
        .quo   (quo),
        .done  (div_done)
    );

    // fused pre-blend sum and gyro angle update
    always_comb
    begin
        s_sum = 64'(fu_reg[cmd.axis]) + inc_a_reg;
        if (s_sum > 64'sd2147483647)       s_sat = 64'sd2147483647;
        else if (s_sum < -64'sd2147483648) s_sat = -64'sd2147483648;
        else                               s_sat = s_sum;
        old_g = inc_b ? gb_reg[cmd.axis] : ga_reg[cmd.axis];
        integ = 64'(old_g) + quo;
        if (wrap_enable)
        begin
            if (integ > 64'(icaf_pkg::PI_Q28))       integ = -64'(icaf_pkg::PI_Q28);
            else if (integ < -64'(icaf_pkg::PI_Q28)) integ = 64'(icaf_pkg::PI_Q28);
        end
        else if (integ > 64'sd2147483647)  integ = 64'sd2147483647;
        else if (integ < -64'sd2147483648) integ = -64'sd2147483648;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ga_reg[k] <= '0;
                gb_reg[k] <= '0;
                fu_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.inc_store && !inc_b) ga_reg[cmd.axis] <= integ[31:0];
            if (cmd.inc_store && inc_b)  gb_reg[cmd.axis] <= integ[31:0];
            if (cmd.blend_store)         fu_reg[cmd.axis] <= quo[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) in_reg <= in_word;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        it_reg <= it_next;
        zero_reg <= zero_next;
        num_reg <= num_next;
        if (cmd.ref_store) ref_reg[cmd.axis] <= zero_reg ? 32'sd0 : cz_reg;
        if (cmd.inc_store && !inc_b) inc_a_reg <= quo;
    end

    assign out_word.gyro_a_roll  = ga_reg[0];
    assign out_word.gyro_a_pitch = ga_reg[1];
    assign out_word.gyro_a_yaw   = ga_reg[2];
    assign out_word.gyro_b_roll  = gb_reg[0];
    assign out_word.gyro_b_pitch = gb_reg[1];
    assign out_word.gyro_b_yaw   = gb_reg[2];
    assign out_word.ref_roll     = ref_reg[0];
    assign out_word.ref_pitch    = ref_reg[1];
    assign out_word.ref_yaw      = ref_reg[2];
    assign out_word.fused_roll   = fu_reg[0];
    assign out_word.fused_pitch  = fu_reg[1];
    assign out_word.fused_yaw    = fu_reg[2];
endmodule
`default_nettype wire

// ===== rtl/imu_complementary_angle_filter_top.sv =====
// Top level of the IMU complementary angle filter: config register, output
// register, controller and datapath. Uses icaf_pkg, icaf_ctrl, icaf_datapath.
//
// One word in, one word out. A new word is taken only once the last is through
// and the output is not stalled: three CORDIC passes on one shared unit, then
// per axis two gyro increments and one blend, each a pass through a shared
// reciprocal-multiply divider whose remainder correction loop varies in length.
// The result sits in an output register; the next word is taken once that
// register is handed off.
`default_nettype none
module imu_complementary_angle_filter_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire icaf_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output icaf_pkg::out_word_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_wdata
);
    logic wrap_reg;
    logic gyro_b;
    icaf_pkg::ctrl_cmd_t  cmd;
    icaf_pkg::ctrl_stat_t stat;
    icaf_pkg::out_word_t  dp_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg  <= 1'b1;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we) wrap_reg <= cfg_wdata[0];
            if (cmd.out_load)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load) out_data <= dp_word;
    end

    icaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_full (out_valid && out_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // second-gyro pass marker follows the controller's divider sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gyro_b <= 1'b0;
        else if (cmd.inc_store)
            gyro_b <= !gyro_b;
        else if (cmd.load)
            gyro_b <= 1'b0;
    end

    icaf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .wrap_enable (wrap_reg),
        .in_word     (in_data),
        .cmd         (cmd),
        .inc_b       (gyro_b),
        .stat        (stat),
        .out_word    (dp_word)
    );
endmodule
`default_nettype wire
